@@ hw/rtl/hsv2rgb_pkg.sv @@
// Shared widths, stage word types and a helper function for the HSV to RGB converter.
package hsv2rgb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IN_W      = 18;
    localparam int UW        = FRAC_BITS + 1;
    localparam int MW        = (IN_W - 1 > UW) ? IN_W - 1 : UW;
    localparam int H6W       = UW + 3;
    localparam int PW        = 2 * UW;

    localparam logic [UW-1:0]  ONE     = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [H6W-1:0] SIX_ONE = H6W'(6) << FRAC_BITS;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

    typedef struct packed {
        logic                 black;
        t_sector              sector;
        logic [FRAC_BITS-1:0] f;
        logic [UW-1:0]        s;
        logic [UW-1:0]        v;
    } t_prep_word;

    typedef struct packed {
        logic          black;
        t_sector       sector;
        logic [UW-1:0] v;
        logic [UW-1:0] p;
        logic [UW-1:0] sf;
        logic [UW-1:0] snf;
    } t_part_word;

    typedef struct packed {
        logic          black;
        t_sector       sector;
        logic [UW-1:0] v;
        logic [UW-1:0] p;
        logic [UW-1:0] q;
        logic [UW-1:0] t;
    } t_term_word;

    // Unit product, truncated back to FRAC_BITS fraction bits; both operands are <= ONE.
    function automatic logic [UW-1:0] mul_unit(input logic [UW-1:0] a, input logic [UW-1:0] b);
        logic [PW-1:0] prod;
        prod = PW'(a) * PW'(b);
        return prod[FRAC_BITS+UW-1:FRAC_BITS];
    endfunction

endpackage

@@ hw/rtl/hsv2rgb_prep.sv @@
// Stage 1: clamp the three components, find the hue sector and its fraction.
module hsv2rgb_prep (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [hsv2rgb_pkg::IN_W-1:0]  i_hue,
    input  logic signed [hsv2rgb_pkg::IN_W-1:0]  i_sat,
    input  logic signed [hsv2rgb_pkg::IN_W-1:0]  i_val,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output hsv2rgb_pkg::t_prep_word              o_word
);
    import hsv2rgb_pkg::*;

    function automatic logic [UW-1:0] clamp_unit(input logic signed [IN_W-1:0] x);
        logic [MW-1:0] m;
        logic [UW-1:0] r;
        m = MW'(x[IN_W-2:0]);
        if (x[IN_W-1]) begin
            r = '0;
        end else if (m > MW'(ONE)) begin
            r = ONE;
        end else begin
            r = m[UW-1:0];
        end
        return r;
    endfunction

    logic            r_vld;
    t_prep_word      r_word;
    t_prep_word      n_word;
    logic [UW-1:0]   h;
    logic [H6W-1:0]  h6_raw;
    logic [H6W-1:0]  h6;

    always_comb begin
        h      = clamp_unit(i_hue);
        h6_raw = H6W'({h, 2'b00}) + H6W'({h, 1'b0});
        // hue of exactly 1.0 wraps to the first sector
        h6     = (h6_raw == SIX_ONE) ? '0 : h6_raw;
        n_word.black  = (h == '0);
        n_word.sector = t_sector'(h6[FRAC_BITS+2:FRAC_BITS]);
        n_word.f      = h6[FRAC_BITS-1:0];
        n_word.s      = clamp_unit(i_sat);
        n_word.v      = clamp_unit(i_val);
    end

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

endmodule

@@ hw/rtl/hsv2rgb_terms.sv @@
// Stages 2 and 3: form p, then q and t, from value, saturation and hue fraction.
module hsv2rgb_terms (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  hsv2rgb_pkg::t_prep_word i_word,
    output logic                    o_valid,
    input  logic                    i_ready,
    output hsv2rgb_pkg::t_term_word o_word
);
    import hsv2rgb_pkg::*;

    logic       r_vld_a;
    t_part_word r_part;
    t_part_word n_part;
    logic       ready_a;
    logic       r_vld_b;
    t_term_word r_term;
    t_term_word n_term;
    logic       ready_b;

    always_comb begin
        n_part.black  = i_word.black;
        n_part.sector = i_word.sector;
        n_part.v      = i_word.v;
        n_part.p      = mul_unit(i_word.v, ONE - i_word.s);
        n_part.sf     = mul_unit(i_word.s, UW'(i_word.f));
        n_part.snf    = mul_unit(i_word.s, ONE - UW'(i_word.f));
    end

    always_comb begin
        n_term.black  = r_part.black;
        n_term.sector = r_part.sector;
        n_term.v      = r_part.v;
        n_term.p      = r_part.p;
        n_term.q      = mul_unit(r_part.v, ONE - r_part.sf);
        n_term.t      = mul_unit(r_part.v, ONE - r_part.snf);
    end

    assign ready_b = !r_vld_b || i_ready;
    assign ready_a = !r_vld_a || ready_b;
    assign o_ready = ready_a;
    assign o_valid = r_vld_b;
    assign o_word  = r_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (ready_a) begin
                r_vld_a <= i_valid;
            end
            if (ready_b) begin
                r_vld_b <= r_vld_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && i_valid) begin
            r_part <= n_part;
        end
        if (ready_b && r_vld_a) begin
            r_term <= n_term;
        end
    end

endmodule

@@ hw/rtl/hsv2rgb_mix.sv @@
// Stage 4: sector mux, scale each channel by 255 and register the output word.
module hsv2rgb_mix (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  hsv2rgb_pkg::t_term_word i_word,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [7:0]              o_red,
    output logic [7:0]              o_green,
    output logic [7:0]              o_blue
);
    import hsv2rgb_pkg::*;

    function automatic logic [7:0] to_byte(input logic [UW-1:0] c);
        logic [UW+7:0] w;
        w = {c, 8'b0} - (UW+8)'(c);
        return w[FRAC_BITS+7:FRAC_BITS];
    endfunction

    logic          r_vld;
    logic [7:0]    r_red;
    logic [7:0]    r_green;
    logic [7:0]    r_blue;
    logic [UW-1:0] red_c;
    logic [UW-1:0] green_c;
    logic [UW-1:0] blue_c;
    logic [7:0]    n_red;
    logic [7:0]    n_green;
    logic [7:0]    n_blue;

    always_comb begin
        case (i_word.sector)
            SEC_RED_YEL: begin
                red_c = i_word.v; green_c = i_word.t; blue_c = i_word.p;
            end
            SEC_YEL_GRN: begin
                red_c = i_word.q; green_c = i_word.v; blue_c = i_word.p;
            end
            SEC_GRN_CYN: begin
                red_c = i_word.p; green_c = i_word.v; blue_c = i_word.t;
            end
            SEC_CYN_BLU: begin
                red_c = i_word.p; green_c = i_word.q; blue_c = i_word.v;
            end
            SEC_BLU_MAG: begin
                red_c = i_word.t; green_c = i_word.p; blue_c = i_word.v;
            end
            SEC_MAG_RED: begin
                red_c = i_word.v; green_c = i_word.p; blue_c = i_word.q;
            end
            default: begin
                red_c = '0; green_c = '0; blue_c = '0;
            end
        endcase
        // zero hue marks a set point: force black
        if (i_word.black) begin
            n_red   = 8'd0;
            n_green = 8'd0;
            n_blue  = 8'd0;
        end else begin
            n_red   = to_byte(red_c);
            n_green = to_byte(green_c);
            n_blue  = to_byte(blue_c);
        end
    end

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

endmodule

@@ hw/rtl/hsv_to_rgb_converter.sv @@
// Top level of the HSV to RGB converter: four-stage pixel pipeline.
//
// Input channel: i_valid / o_ready carry one HSV word (hue, saturation,
// value), each 18-bit signed fixed point with 16 fraction bits, clamped
// to 0..1.0 inside. Output channel: o_valid / i_ready carry one RGB word,
// three 8-bit channels, each 255 times its component, truncated.
// A hue of zero gives black.
//
// A word passes through the stage registers in order: clamp and sector,
// first products (p and the saturation-fraction terms), q and t, then
// the sector mux with byte scaling into the output register. One word
// enters per cycle as long as the receiver takes words.
//
// Reset clears every stage valid bit; the pipeline comes up empty and
// ready. When the receiver stalls, the output word holds and each stage
// keeps its word until the stage ahead frees up; empty stages still fill,
// so up to four words are taken before o_ready drops.
module hsv_to_rgb_converter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [hsv2rgb_pkg::IN_W-1:0] i_hue_in,
    input  logic signed [hsv2rgb_pkg::IN_W-1:0] i_saturation_in,
    input  logic signed [hsv2rgb_pkg::IN_W-1:0] i_brightness_in,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [7:0]                          o_red_out,
    output logic [7:0]                          o_green_out,
    output logic [7:0]                          o_blue_out
);
    import hsv2rgb_pkg::*;

    logic       prep_vld;
    logic       prep_rdy;
    t_prep_word prep_word;
    logic       term_vld;
    logic       term_rdy;
    t_term_word term_word;

    hsv2rgb_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_hue   (i_hue_in),
        .i_sat   (i_saturation_in),
        .i_val   (i_brightness_in),
        .o_valid (prep_vld),
        .i_ready (prep_rdy),
        .o_word  (prep_word)
    );

    hsv2rgb_terms u_terms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prep_vld),
        .o_ready (prep_rdy),
        .i_word  (prep_word),
        .o_valid (term_vld),
        .i_ready (term_rdy),
        .o_word  (term_word)
    );

    hsv2rgb_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (term_vld),
        .o_ready (term_rdy),
        .i_word  (term_word),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_red   (o_red_out),
        .o_green (o_green_out),
        .o_blue  (o_blue_out)
    );

    // an empty output stage lets every stage behind it advance
    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while output stage empty");

    a_taken_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("input stalled while receiver takes words");

    a_stage_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (term_vld && term_rdy) |=> o_valid)
        else $error("word lost between term stage and output stage");

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the HSV to RGB pixel converter.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hsv2rgb_pkg::*;

    localparam longint UNIT_FX    = 64'd1 << FRAC_BITS;
    localparam int     RAND_PX    = 550;
    localparam int     TAIL_PX    = 60;
    localparam int     LIMIT      = 200000;
    localparam int     LONG_STALL = 100;
    localparam int     STALL_AT   = 200;

    typedef logic signed [IN_W-1:0] comp_t;

    typedef struct {
        comp_t hue;
        comp_t sat;
        comp_t bri;
        bit    wait_empty;
    } pixel_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    logic  i_clk           = 1'b0;
    logic  i_rst_n         = 1'b0;
    logic  i_valid         = 1'b0;
    logic  i_ready         = 1'b0;
    comp_t i_hue_in        = '0;
    comp_t i_saturation_in = '0;
    comp_t i_brightness_in = '0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_red_out;
    logic [7:0] o_green_out;
    logic [7:0] o_blue_out;

    pixel_t pending_px[$];
    rgb_t   expected_rgb[$];

    int total_px     = 0;
    int px_accepted  = 0;
    int rgb_seen     = 0;
    int black_seen   = 0;
    int errors       = 0;
    int cycle_count  = 0;
    int tx_gap       = 0;
    int rx_gap       = 0;
    int stall_left   = 0;
    bit stall_done   = 1'b0;

    hsv_to_rgb_converter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_hue_in        (i_hue_in),
        .i_saturation_in (i_saturation_in),
        .i_brightness_in (i_brightness_in),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_red_out       (o_red_out),
        .o_green_out     (o_green_out),
        .o_blue_out      (o_blue_out)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    function automatic longint clamp_component(comp_t raw);
        longint wide;
        wide = raw;
        if (wide < 0) return 0;
        if (wide > UNIT_FX) return UNIT_FX;
        return wide;
    endfunction

    function automatic longint frac_product(longint a, longint b);
        return (a * b) >>> FRAC_BITS;
    endfunction

    function automatic rgb_t predict_rgb(comp_t hue, comp_t sat, comp_t bri);
        longint  h, s, v, h6, f, p, q, t, r, g, b;
        t_sector sec;
        rgb_t    res;
        h = clamp_component(hue);
        s = clamp_component(sat);
        v = clamp_component(bri);
        res = '0;
        if (h == 0) return res;
        h6 = 6 * h;
        // full-turn hue folds back into the first sector
        if (h6 == 6 * UNIT_FX) h6 = 0;
        sec = t_sector'(3'(h6 >>> FRAC_BITS));
        f = h6 & (UNIT_FX - 1);
        p = frac_product(v, UNIT_FX - s);
        q = frac_product(v, UNIT_FX - frac_product(s, f));
        t = frac_product(v, UNIT_FX - frac_product(s, UNIT_FX - f));
        case (sec)
            SEC_RED_YEL: begin r = v; g = t; b = p; end
            SEC_YEL_GRN: begin r = q; g = v; b = p; end
            SEC_GRN_CYN: begin r = p; g = v; b = t; end
            SEC_CYN_BLU: begin r = p; g = q; b = v; end
            SEC_BLU_MAG: begin r = t; g = p; b = v; end
            SEC_MAG_RED: begin r = v; g = p; b = q; end
            default: begin r = 0; g = 0; b = 0; end
        endcase
        res.red   = 8'((255 * r) >>> FRAC_BITS);
        res.green = 8'((255 * g) >>> FRAC_BITS);
        res.blue  = 8'((255 * b) >>> FRAC_BITS);
        return res;
    endfunction

    task automatic report_mismatch(string what, int idx, int got, int want);
        if (errors < 40)
            $display("mismatch %s at word %0d: got %0d, want %0d", what, idx, got, want);
        errors++;
    endtask

    task automatic add_px(int hue, int sat, int bri, bit wait_empty = 1'b0);
        pixel_t px;
        px.hue        = comp_t'(hue);
        px.sat        = comp_t'(sat);
        px.bri        = comp_t'(bri);
        px.wait_empty = wait_empty;
        pending_px.push_back(px);
        total_px++;
    endtask

    function automatic int rand_component();
        case ($urandom_range(0, 9))
            0: return int'(comp_t'($urandom));
            1: begin
                case ($urandom_range(0, 7))
                    0: return 0;
                    1: return 1;
                    2: return 65535;
                    3: return 65536;
                    4: return 65537;
                    5: return -1;
                    6: return -131072;
                    default: return 131071;
                endcase
            end
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    // idle-free stretches: one phase in four, and the tail of the run
    function automatic bit quiet_phase();
        return ((px_accepted / 64) % 4 == 3) || (px_accepted >= total_px - TAIL_PX);
    endfunction

    always @(posedge i_clk) begin : sender
        bit offer;
        pixel_t nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                expected_rgb.push_back(predict_rgb(i_hue_in, i_saturation_in, i_brightness_in));
                px_accepted <= px_accepted + 1;
            end
            offer = 1'b0;
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
            end else if (pending_px.size() != 0 &&
                         !(pending_px[0].wait_empty && expected_rgb.size() != 0)) begin
                if (!quiet_phase() && $urandom_range(0, 5) == 0) begin
                    tx_gap <= $urandom_range(0, 15);
                end else begin
                    nxt = pending_px.pop_front();
                    i_hue_in        <= nxt.hue;
                    i_saturation_in <= nxt.sat;
                    i_brightness_in <= nxt.bri;
                    offer = 1'b1;
                end
            end
            i_valid <= offer;
        end
    end

    // one long receiver hold-off while the sender keeps offering words
    always @(posedge i_clk) begin : long_stall
        if (i_rst_n) begin
            if (!stall_done && px_accepted >= STALL_AT) begin
                stall_left <= LONG_STALL;
                stall_done <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
            end
        end
    end

    always @(posedge i_clk) begin : receiver
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (stall_left != 0) begin
            i_ready <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap  <= rx_gap - 1;
            i_ready <= 1'b0;
        end else if (!quiet_phase() && $urandom_range(0, 6) == 0) begin
            rx_gap  <= $urandom_range(0, 15);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : monitor
        rgb_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_rgb.size() == 0) begin
                report_mismatch("unexpected word", rgb_seen, 1, 0);
            end else begin
                want = expected_rgb.pop_front();
                if (want == '0) black_seen++;
                if (o_red_out !== want.red)
                    report_mismatch("red", rgb_seen, o_red_out, want.red);
                if (o_green_out !== want.green)
                    report_mismatch("green", rgb_seen, o_green_out, want.green);
                if (o_blue_out !== want.blue)
                    report_mismatch("blue", rgb_seen, o_blue_out, want.blue);
            end
            rgb_seen++;
        end
    end

    initial begin : watchdog
        while (cycle_count < LIMIT) @(posedge i_clk);
        $display("[hsv_to_rgb_converter] ERROR");
        $finish;
    end

    initial begin : main
        int h;
        // black, clamping and wrap at full turn
        add_px(0, 65536, 65536);
        add_px(-1, 65536, 65536);
        add_px(-131072, -131072, -131072);
        add_px(131071, 131071, 131071);
        add_px(65536, 65536, 65536);
        add_px(1, 65536, 65536);
        add_px(65535, 65536, 65536);
        // both sides of every sector boundary
        add_px(10922, 65536, 65536);
        add_px(10923, 65536, 65536);
        add_px(21845, 65536, 65536);
        add_px(21846, 65536, 65536);
        add_px(32767, 65536, 65536);
        add_px(32768, 65536, 65536);
        add_px(43690, 65536, 65536);
        add_px(43691, 65536, 65536);
        add_px(54613, 65536, 65536);
        add_px(54614, 65536, 65536);
        add_px(27307, 50000, 60000);
        add_px(49152, 30000, 65536);
        add_px(60075, 65536, 40000);
        // saturation and value extremes
        add_px(16384, 0, 65536);
        add_px(16384, -5, 65536);
        add_px(40000, 131071, 50000);
        add_px(27307, 65536, 0);
        add_px(49152, 40000, -1, 1'b1);

        for (int i = 0; i < RAND_PX; i++) begin
            h = rand_component();
            // land near a sector boundary now and then
            if ($urandom_range(0, 7) == 0)
                h = ($urandom_range(1, 5) * 65536) / 6 + $urandom_range(0, 4) - 2;
            add_px(h, rand_component(), rand_component(), (i == 300) || (i == 450));
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (px_accepted != total_px || i_valid) @(posedge i_clk);
        while (expected_rgb.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (expected_rgb.size() != 0)
            report_mismatch("missing words", rgb_seen, 0, expected_rgb.size());

        $display("run covered %0d pixels, %0d results (%0d black), %0d cycles",
                 px_accepted, rgb_seen, black_seen, cycle_count);
        $display("with a long output stall, drain pauses and random idling on both sides");
        if (errors == 0) begin
            $display("[hsv_to_rgb_converter] OK");
        end else begin
            $display("[hsv_to_rgb_converter] ERROR");
        end
        $finish;
    end
endmodule
